// ===== rtl/core/clt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the command line tokenizer
// Holds the event codes, character codes, parameter defaults and the request
// that travels from the front end to the event sequencer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int MAX_ARGS_DEF    = 8;
  localparam int TOKEN_BUF_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  localparam logic [1:0] EV_CHAR     = 2'd0;
  localparam logic [1:0] EV_ARG_END  = 2'd1;
  localparam logic [1:0] EV_LINE_END = 2'd2;

  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  // One request: up to three events caused by one input byte, in the order
  // character, argument end, line end.
  typedef struct packed {
    logic       has_char;
    logic       has_end;
    logic       has_line;
    logic [2:0] arg_index;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic [3:0] token_length;
    logic [3:0] arg_count;
  } evt_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/clt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_front: byte classifier and tokenizer state
// Accepts one byte per cycle while the queue has room, advances the phase and
// counters, and queues a request for the events of that byte, if it has any.
// ----------------------------------------------------------------------------
module clt_front #(
  parameter int MAX_ARGS  = clt_pkg::MAX_ARGS_DEF,
  parameter int TOKEN_BUF = clt_pkg::TOKEN_BUF_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_eol,
  output logic                   in_ready,
  input  wire logic              q_full,
  output logic                   q_push,
  output clt_pkg::evt_req_t      q_req
);

  localparam int AW = $clog2(MAX_ARGS + 1);
  localparam int CW = (TOKEN_BUF > 2) ? $clog2(TOKEN_BUF) : 1;
  localparam logic [AW-1:0] AC_MAX   = AW'(MAX_ARGS);
  localparam logic [CW:0]   CC_LIMIT = (CW + 1)'(TOKEN_BUF - 1);

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_PLAIN   = 6'b000010,
    PH_QUOTED  = 6'b000100,
    PH_ESCAPE  = 6'b001000,
    PH_SKIPQ   = 6'b010000,
    PH_FULL    = 6'b100000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [AW-1:0]   ac_r, ac_nxt;
  logic [CW-1:0]   cc_r, cc_nxt;

  logic            accept;
  logic            eol;
  logic            between_path;
  logic            do_store;
  logic            do_close;
  logic            st_quoted;
  logic [7:0]      st_val;
  logic [CW-1:0]   st_base;
  logic [CW:0]     cc_inc;
  logic [AW:0]     ac_inc;
  logic            ac_full;
  logic [CW:0]     len_val;
  logic [AW:0]     cnt_val;
  logic [CW-1:0]   pos_val;
  logic [7:0]      val_out;
  logic            has_char, has_end, has_line;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign eol      = in_eol || (in_byte == clt_pkg::CH_NUL);
  assign ac_inc   = {1'b0, ac_r} + (AW + 1)'(1);
  assign ac_full  = (ac_inc >= (AW + 1)'(MAX_ARGS));

  always_comb begin
    phase_nxt    = phase_r;
    ac_nxt       = ac_r;
    cc_nxt       = cc_r;
    has_char     = 1'b0;
    has_end      = 1'b0;
    has_line     = 1'b0;
    between_path = 1'b0;
    do_store     = 1'b0;
    do_close     = 1'b0;
    st_quoted    = 1'b0;
    st_val       = in_byte;
    st_base      = cc_r;
    cc_inc       = '0;
    len_val      = {1'b0, cc_r};
    cnt_val      = {1'b0, ac_r};
    pos_val      = cc_r;
    val_out      = in_byte;

    if (eol) begin
      has_line = 1'b1;
      case (phase_r)
        PH_ESCAPE: begin
          // dangling backslash is kept as itself
          has_char = 1'b1;
          val_out  = clt_pkg::CH_BACKSLASH;
          has_end  = 1'b1;
          len_val  = {1'b0, cc_r} + (CW + 1)'(1);
          cnt_val  = ac_inc;
        end
        PH_PLAIN, PH_QUOTED: begin
          has_end = 1'b1;
          cnt_val = ac_inc;
        end
        default: begin
          cnt_val = {1'b0, ac_r};
        end
      endcase
      phase_nxt = PH_BETWEEN;
      ac_nxt    = '0;
      cc_nxt    = '0;
    end else begin
      case (phase_r)
        PH_SKIPQ: begin
          if (in_byte == clt_pkg::CH_QUOTE) begin
            phase_nxt = PH_BETWEEN;
          end else begin
            between_path = 1'b1;
          end
        end
        PH_BETWEEN: begin
          between_path = 1'b1;
        end
        PH_PLAIN: begin
          if (in_byte == clt_pkg::CH_SPACE) begin
            do_close = 1'b1;
          end else begin
            do_store = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (in_byte == clt_pkg::CH_QUOTE) begin
            do_close = 1'b1;
          end else if (in_byte == clt_pkg::CH_BACKSLASH) begin
            phase_nxt = PH_ESCAPE;
          end else begin
            do_store  = 1'b1;
            st_quoted = 1'b1;
          end
        end
        PH_ESCAPE: begin
          phase_nxt = PH_QUOTED;
          do_store  = 1'b1;
          st_quoted = 1'b1;
          st_val    = (in_byte == clt_pkg::CH_N) ? clt_pkg::CH_NEWLINE : in_byte;
        end
        default: begin
        end
      endcase

      if (between_path) begin
        st_base = '0;
        if (in_byte == clt_pkg::CH_SPACE) begin
          phase_nxt = PH_BETWEEN;
        end else if (in_byte == clt_pkg::CH_QUOTE) begin
          phase_nxt = PH_QUOTED;
          cc_nxt    = '0;
        end else begin
          phase_nxt = PH_PLAIN;
          do_store  = 1'b1;
        end
      end

      if (do_store) begin
        has_char = 1'b1;
        val_out  = st_val;
        pos_val  = st_base;
        cc_inc   = {1'b0, st_base} + (CW + 1)'(1);
        cc_nxt   = cc_inc[CW-1:0];
        // full argument: close it on the spot
        if (cc_inc == CC_LIMIT) begin
          has_end = 1'b1;
          len_val = cc_inc;
          ac_nxt  = ac_inc[AW-1:0];
          cc_nxt  = '0;
          if (ac_full) begin
            phase_nxt = PH_FULL;
          end else if (st_quoted) begin
            phase_nxt = PH_SKIPQ;
          end else begin
            phase_nxt = PH_BETWEEN;
          end
        end
      end

      if (do_close) begin
        has_end   = 1'b1;
        len_val   = {1'b0, cc_r};
        ac_nxt    = ac_inc[AW-1:0];
        cc_nxt    = '0;
        phase_nxt = ac_full ? PH_FULL : PH_BETWEEN;
      end
    end
  end

  always_comb begin
    q_req.has_char     = has_char;
    q_req.has_end      = has_end;
    q_req.has_line     = has_line;
    q_req.arg_index    = 3'(ac_r);
    q_req.char_pos     = 4'(pos_val);
    q_req.char_value   = val_out;
    q_req.token_length = 4'(len_val);
    q_req.arg_count    = 4'(cnt_val);
  end

  assign q_push = accept && (has_char || has_end || has_line);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BETWEEN;
      ac_r    <= '0;
      cc_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      ac_r    <= ac_nxt;
      cc_r    <= cc_nxt;
    end
  end

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FULL) |-> (ac_r == AC_MAX))
    else $error("full phase without the maximum argument count");

  a_idle_no_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BETWEEN || phase_r == PH_SKIPQ || phase_r == PH_FULL)
      |-> (cc_r == '0))
    else $error("character count left over outside an argument");

endmodule
`default_nettype wire

// ===== rtl/core/clt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_queue: request queue between front end and event sequencer
// Small register FIFO; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module clt_queue #(
  parameter int DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire clt_pkg::evt_req_t push_req,
  output logic                   full,
  input  wire logic              pop,
  output clt_pkg::evt_req_t      pop_req,
  output logic                   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [NW-1:0] CNT_MAX  = NW'(DEPTH);

  clt_pkg::evt_req_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_MAX);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_req = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + NW'(1);
        2'b01:   count_r <= count_r - NW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("queue count beyond its depth");

endmodule
`default_nettype wire

// ===== rtl/core/clt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_back: event sequencer
// Takes requests from the queue and issues their events one per cycle into
// the output register unless stalled, marking the final event of each request.
// ----------------------------------------------------------------------------
module clt_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  wire clt_pkg::evt_req_t                   q_req,
  output logic                                     q_pop,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [clt_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic [clt_pkg::OUT_TUSER_W-1:0]          out_tuser,
  output logic                                     out_tlast
);

  clt_pkg::evt_req_t cur_r;
  logic [2:0]        rem_r;       // pending events: line, end, char
  logic [2:0]        rem_after;
  logic              out_valid_r;
  logic [clt_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [clt_pkg::OUT_TUSER_W-1:0] out_user_r;
  logic              out_last_r;
  logic              load_out;
  logic              issue;
  logic [1:0]        kind;
  logic [2:0]        idx;
  logic [3:0]        pos;
  logic [7:0]        val;
  logic [3:0]        len;
  logic [3:0]        cnt;

  assign load_out = !out_valid_r || out_tready;
  assign issue    = load_out && (rem_r != 3'b000);

  always_comb begin
    rem_after = rem_r;
    kind      = clt_pkg::EV_LINE_END;
    idx       = '0;
    pos       = '0;
    val       = '0;
    len       = '0;
    cnt       = '0;
    if (rem_r[0]) begin
      kind = clt_pkg::EV_CHAR;
      idx  = cur_r.arg_index;
      pos  = cur_r.char_pos;
      val  = cur_r.char_value;
      if (issue) begin
        rem_after[0] = 1'b0;
      end
    end else if (rem_r[1]) begin
      kind = clt_pkg::EV_ARG_END;
      idx  = cur_r.arg_index;
      len  = cur_r.token_length;
      if (issue) begin
        rem_after[1] = 1'b0;
      end
    end else begin
      cnt = cur_r.arg_count;
      if (issue) begin
        rem_after[2] = 1'b0;
      end
    end
  end

  // refill as soon as the current request has nothing left to issue
  assign q_pop = (rem_after == 3'b000) && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_req;
    end
    if (issue) begin
      out_data_r <= {1'b0, cnt, len, val, pos, idx};
      out_user_r <= kind;
      out_last_r <= (rem_after == 3'b000);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rem_r <= {q_req.has_line, q_req.has_end, q_req.has_char};
      end else begin
        rem_r <= rem_after;
      end
      if (load_out) begin
        out_valid_r <= issue;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == clt_pkg::EV_LINE_END) |-> out_tlast)
    else $error("line end not marked as final event");

endmodule
`default_nettype wire

// ===== rtl/core/command_line_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer: streaming shell command line tokenizer
// Splits a byte stream into arguments and reports characters, argument ends
// and line ends as events.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: char_byte; tlast: end_of_line
//  out_    | out | out_tvalid/out_tready | tdata: event fields; tuser: event_kind;
//          |     |                       | tlast: last
//
//  A byte is accepted every cycle while the request queue has room.
//  Each byte yields zero to three events; the sequencer issues one event per
//  cycle while the output is not stalled, and the queue (QUEUE_DEPTH requests)
//  absorbs the difference. An accepted byte's first event passes through the
//  queue, the request register and the output register.
//  Reset is synchronous, active low, and needs no clearing pass.
//  Either side may stall independently; a stalled output holds its event.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int MAX_ARGS    = clt_pkg::MAX_ARGS_DEF,
  parameter int TOKEN_BUF   = clt_pkg::TOKEN_BUF_DEF,
  parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] char_byte
  input  wire logic                        in_tlast,   // end_of_line
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [2:0] arg_index, [6:3] char_pos, [14:7] char_value, [18:15] token_length,
  // [22:19] arg_count, [23] zero
  output logic [clt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [clt_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [1:0] event_kind
  output logic                             out_tlast   // last
);

  clt_pkg::evt_req_t push_req;
  clt_pkg::evt_req_t pop_req;
  logic              q_push, q_full, q_pop, q_empty;

  clt_front #(
    .MAX_ARGS  (MAX_ARGS),
    .TOKEN_BUF (TOKEN_BUF)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_eol   (in_tlast),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (push_req)
  );

  clt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  clt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_req      (pop_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
